// File: rtl/generalized_hilbert_curve_walker_macros.svh
// assertion macros shared by the walker modules
`ifndef GENERALIZED_HILBERT_CURVE_WALKER_MACROS_SVH
`define GENERALIZED_HILBERT_CURVE_WALKER_MACROS_SVH

// property must hold at every clock edge out of reset
`define GHCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define GHCW_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/ghcw_pkg.sv
// shared types and constants of the hilbert curve walker
package ghcw_pkg;

  // configuration register fields
  localparam int unsigned DIM_REG_W = 13;
  localparam logic [DIM_REG_W-1:0] DIM_RESET = 13'd256;

  // register index, taken from paddr bit 2
  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  // result field widths
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned RASTER_W = 24;

  // child numbers kept in a stack frame
  localparam int unsigned PHASE_W = 2;
  localparam logic [PHASE_W-1:0] PHASE_FIRST  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_SECOND = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_THIRD  = 2'd2;

  // request handed from the front to the back
  typedef struct packed {
    logic valid;
    logic restart;
  } req_t;

endpackage

// File: rtl/ghcw_ram.sv
// generic single write, single registered read ram
module ghcw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/ghcw_front.sv
// front: configuration registers and the request queue
`include "generalized_hilbert_curve_walker_macros.svh"

module ghcw_front #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         restart_i,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // towards the back
  output ghcw_pkg::req_t               req_o,
  input  logic                         take_i,
  output logic [$clog2(MAX_DIM+1)-1:0] dim_w_o,
  output logic [$clog2(MAX_DIM+1)-1:0] dim_h_o
);
  import ghcw_pkg::*;

  localparam int unsigned DIMW = $clog2(MAX_DIM + 1);

  logic [DIM_REG_W-1:0] width_q, height_q;
  logic                 wr_acc;
  logic [1:0]           count_q, count_d;
  logic                 wr_ptr_q, rd_ptr_q;
  logic                 slot_q [2];
  logic                 push, pop;

  // register writes
  assign pready = 1'b1;
  assign wr_acc = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (wr_acc) begin
      if (paddr[2] == REG_IDX_WIDTH) begin
        width_q <= pwdata[DIM_REG_W-1:0];
      end else begin
        height_q <= pwdata[DIM_REG_W-1:0];
      end
    end
  end

  // register reads
  assign prdata = (paddr[2] == REG_IDX_HEIGHT) ? 32'(height_q) : 32'(width_q);

  // clamp a dimension into one to max
  function automatic logic [DIMW-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
    if (v == '0) begin
      return DIMW'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      return DIMW'(MAX_DIM);
    end else begin
      return DIMW'(v);
    end
  endfunction

  assign dim_w_o = clamp_dim(width_q);
  assign dim_h_o = clamp_dim(height_q);

  // two-entry request queue
  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i & ~in_stall_o;
  assign pop        = take_i & (count_q != 2'd0);

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= restart_i;
    end
  end

  assign req_o.valid   = (count_q != 2'd0);
  assign req_o.restart = slot_q[rd_ptr_q];

  `GHCW_NEVER(a_count_bound, count_q == 2'd3, "request queue overfilled")
  `GHCW_ASSERT(a_ptr_match, (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q), "queue pointers out of step")
  `GHCW_ASSERT(a_pop_push, (pop && !push) |=> (count_q == $past(count_q) - 2'd1), "queue count lost a beat")

endmodule

// File: rtl/ghcw_back.sv
// back: split stack sequencer and leaf run stepper
`include "generalized_hilbert_curve_walker_macros.svh"

module ghcw_back #(
  parameter int unsigned MAX_DIM     = 4096,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ghcw_pkg::req_t               req_i,
  output logic                         take_o,
  input  logic [$clog2(MAX_DIM+1)-1:0] dim_w_i,
  input  logic [$clog2(MAX_DIM+1)-1:0] dim_h_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ghcw_pkg::COORD_W-1:0] point_x_o,
  output logic [ghcw_pkg::COORD_W-1:0] point_y_o,
  output logic [ghcw_pkg::RASTER_W-1:0] raster_index_o,
  output logic                         last_point_o
);
  import ghcw_pkg::*;

  localparam int unsigned DIMW = $clog2(MAX_DIM + 1);
  localparam int unsigned CW   = DIMW + 1;
  localparam int unsigned TW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW   = $clog2(STACK_DEPTH);
  localparam int unsigned FW   = 6 * CW + PHASE_W;
  localparam int unsigned PW   = COORD_W + DIMW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ENTER = 3'd1;
  localparam logic [2:0] S_ADV   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  typedef logic signed [CW-1:0] crd_t;

  logic [2:0]  state_q;
  logic        active_q, pend_q, more_q, out_valid_q;
  logic [TW-1:0] top_q;
  logic [DIMW-1:0] rem_q, cur_w_q;
  crd_t        bx_q, by_q, bax_q, bay_q, bbx_q, bby_q;
  crd_t        run_x_q, run_y_q, run_dx_q, run_dy_q;
  logic [COORD_W-1:0] pt_x_q, pt_y_q;
  logic [COORD_W-1:0] ox_q, oy_q;
  logic [RASTER_W-1:0] oraster_q;
  logic        olast_q;

  // stack memory ports
  logic          st_we, st_re;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [FW-1:0] st_wdata, st_rdata;
  crd_t          rx, ry, rax, ray, rbx, rby;
  logic [PHASE_W-1:0] rph;

  // split unit
  crd_t sx, sy, sax, say, sbx, sby;
  logic [PHASE_W-1:0] sk;
  crd_t suma, sumb, sw, sh, dax, day, dbx, dby, ax2, ay2, bx2, by2, w2, h2;
  crd_t cx, cy, cax, cay, cbx, cby;
  logic [CW+1:0] w_x2, h_x3;
  logic wide, sdone;

  logic full, out_free, root_x;
  logic [PW-1:0] prod;

  function automatic crd_t sgn(input crd_t v);
    if (v[CW-1]) begin
      return '1;
    end else if (v != '0) begin
      return CW'(1);
    end else begin
      return '0;
    end
  endfunction

  function automatic crd_t absv(input crd_t v);
    return v[CW-1] ? -v : v;
  endfunction

  assign {rx, ry, rax, ray, rbx, rby, rph} = st_rdata;

  ghcw_ram #(
    .WIDTH(FW),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (st_we),
    .wr_addr_i (st_waddr),
    .wr_data_i (st_wdata),
    .rd_en_i   (st_re),
    .rd_addr_i (st_raddr),
    .rd_data_o (st_rdata)
  );

  // split of one box into its k-th child
  always_comb begin
    if (state_q == S_POP) begin
      sx = rx; sy = ry; sax = rax; say = ray; sbx = rbx; sby = rby; sk = rph;
    end else begin
      sx = bx_q; sy = by_q; sax = bax_q; say = bay_q; sbx = bbx_q; sby = bby_q;
      sk = PHASE_FIRST;
    end
    suma = sax + say;
    sumb = sbx + sby;
    sw   = absv(suma);
    sh   = absv(sumb);
    dax  = sgn(sax);
    day  = sgn(say);
    dbx  = sgn(sbx);
    dby  = sgn(sby);
    ax2  = sax >>> 1;
    ay2  = say >>> 1;
    bx2  = sbx >>> 1;
    by2  = sby >>> 1;
    w2   = absv(ax2 + ay2);
    h2   = absv(bx2 + by2);
    w_x2 = (CW+2)'(unsigned'(sw)) << 1;
    h_x3 = ((CW+2)'(unsigned'(sh)) << 1) + (CW+2)'(unsigned'(sh));
    wide = (w_x2 > h_x3);
    cx = sx; cy = sy; cax = sax; cay = say; cbx = sbx; cby = sby;
    if (wide) begin
      if (w2[0] && (sw > CW'(2))) begin
        ax2 = ax2 + dax;
        ay2 = ay2 + day;
      end
      sdone = (sk >= PHASE_THIRD);
      if (sk == PHASE_FIRST) begin
        cax = ax2; cay = ay2;
      end else begin
        cx = sx + ax2; cy = sy + ay2;
        cax = sax - ax2; cay = say - ay2;
      end
    end else begin
      if (h2[0] && (sh > CW'(2))) begin
        bx2 = bx2 + dbx;
        by2 = by2 + dby;
      end
      sdone = (sk > PHASE_THIRD);
      case (sk)
        PHASE_FIRST: begin
          cax = bx2; cay = by2; cbx = ax2; cby = ay2;
        end
        PHASE_SECOND: begin
          cx = sx + bx2; cy = sy + by2;
          cbx = sbx - bx2; cby = sby - by2;
        end
        default: begin
          cx  = sx + (sax - dax) + (bx2 - dbx);
          cy  = sy + (say - day) + (by2 - dby);
          cax = -bx2; cay = -by2;
          cbx = -(sax - ax2); cby = -(say - ay2);
        end
      endcase
    end
  end

  assign full     = (top_q == TW'(STACK_DEPTH));
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign root_x   = (dim_w_i >= dim_h_i);
  assign take_o   = (state_q == S_IDLE) & req_i.valid;
  assign prod     = PW'(pt_y_q) * PW'(cur_w_q);

  // stack access
  always_comb begin
    st_we    = 1'b0;
    st_waddr = top_q[AW-1:0];
    st_wdata = {bx_q, by_q, bax_q, bay_q, bbx_q, bby_q, PHASE_SECOND};
    st_re    = (state_q == S_RD);
    st_raddr = AW'(top_q - TW'(1));
    if (state_q == S_ENTER && sh != CW'(1) && sw != CW'(1) && sw != '0 && sh != '0 && !full) begin
      st_we = 1'b1;
    end else if (state_q == S_POP && !sdone) begin
      st_we    = 1'b1;
      st_waddr = AW'(top_q - TW'(1));
      st_wdata = {rx, ry, rax, ray, rbx, rby, rph + PHASE_W'(1)};
    end
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      pend_q      <= 1'b0;
      more_q      <= 1'b0;
      top_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            if (req_i.restart || !active_q) begin
              active_q <= 1'b1;
              pend_q   <= 1'b0;
              top_q    <= '0;
              state_q  <= S_ENTER;
            end else begin
              pend_q  <= 1'b1;
              rem_q   <= rem_q - DIMW'(1);
              state_q <= S_ADV;
            end
          end
        end
        S_ENTER: begin
          if (sh == CW'(1)) begin
            rem_q   <= DIMW'(unsigned'(sw));
            state_q <= S_ADV;
          end else if (sw == CW'(1)) begin
            rem_q   <= DIMW'(unsigned'(sh));
            state_q <= S_ADV;
          end else if (sw == '0 || sh == '0 || full) begin
            rem_q   <= '0;
            state_q <= S_ADV;
          end else begin
            top_q <= top_q + TW'(1);
          end
        end
        S_ADV: begin
          if (rem_q != '0) begin
            if (!pend_q) begin
              pend_q <= 1'b1;
              rem_q  <= rem_q - DIMW'(1);
            end else begin
              more_q  <= 1'b1;
              state_q <= S_EMIT;
            end
          end else if (top_q == '0) begin
            if (pend_q) begin
              more_q  <= 1'b0;
              state_q <= S_EMIT;
            end else begin
              active_q <= 1'b0;
              state_q  <= S_IDLE;
            end
          end else begin
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_POP;
        end
        S_POP: begin
          if (sdone) begin
            top_q   <= top_q - TW'(1);
            state_q <= S_ADV;
          end else begin
            state_q <= S_ENTER;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            active_q    <= more_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // box, run and result payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.restart || !active_q) begin
            cur_w_q <= dim_w_i;
            bx_q <= '0; by_q <= '0;
            if (root_x) begin
              bax_q <= CW'(dim_w_i); bay_q <= '0;
              bbx_q <= '0;           bby_q <= CW'(dim_h_i);
            end else begin
              bax_q <= '0;           bay_q <= CW'(dim_h_i);
              bbx_q <= CW'(dim_w_i); bby_q <= '0;
            end
          end else begin
            pt_x_q  <= COORD_W'(unsigned'(run_x_q));
            pt_y_q  <= COORD_W'(unsigned'(run_y_q));
            run_x_q <= run_x_q + run_dx_q;
            run_y_q <= run_y_q + run_dy_q;
          end
        end
      end
      S_ENTER: begin
        run_x_q <= bx_q;
        run_y_q <= by_q;
        if (sh == CW'(1)) begin
          run_dx_q <= dax; run_dy_q <= day;
        end else if (sw == CW'(1)) begin
          run_dx_q <= dbx; run_dy_q <= dby;
        end else begin
          run_dx_q <= '0; run_dy_q <= '0;
        end
        bx_q <= cx; by_q <= cy; bax_q <= cax; bay_q <= cay; bbx_q <= cbx; bby_q <= cby;
      end
      S_ADV: begin
        if (rem_q != '0 && !pend_q) begin
          pt_x_q  <= COORD_W'(unsigned'(run_x_q));
          pt_y_q  <= COORD_W'(unsigned'(run_y_q));
          run_x_q <= run_x_q + run_dx_q;
          run_y_q <= run_y_q + run_dy_q;
        end
      end
      S_POP: begin
        bx_q <= cx; by_q <= cy; bax_q <= cax; bay_q <= cay; bbx_q <= cbx; bby_q <= cby;
      end
      S_EMIT: begin
        if (out_free) begin
          ox_q      <= pt_x_q;
          oy_q      <= pt_y_q;
          oraster_q <= RASTER_W'(prod) + RASTER_W'(pt_x_q);
          olast_q   <= ~more_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign point_x_o      = ox_q;
  assign point_y_o      = oy_q;
  assign raster_index_o = oraster_q;
  assign last_point_o   = olast_q;

  `GHCW_NEVER(a_top_bound, 32'(top_q) > 32'(STACK_DEPTH), "stack pointer beyond depth")
  `GHCW_ASSERT(a_pop_nonempty, (state_q == S_RD || state_q == S_POP) |-> (top_q != '0), "pop from empty stack")
  `GHCW_ASSERT(a_out_from_emit, $rose(out_valid_q) |-> ($past(state_q) == S_EMIT), "beat raised outside emit")
  `GHCW_ASSERT(a_emit_has_point, (state_q == S_EMIT) |-> pend_q, "emit without a captured point")

endmodule

// File: rtl/generalized_hilbert_curve_walker.sv
// top level of the generalized hilbert curve walker
//
//  channel | direction | handshake              | beat
//  in      | input     | in_valid_i, in_stall_o | restart_i
//  out     | output    | out_valid_o, out_stall_i | point_x_o, point_y_o, raster_index_o,
//          |           |                        | last_point_o
//  cfg     | input     | psel, penable, pwrite  | paddr, pwdata (rect_width at 0, rect_height at 4)
//
// a point inside a leaf run passes the idle, advance and emit states; each frame push
// passes the enter state and each pop the read and pop states (stack ram read plus the
// split unit), so a point takes longer where the walk crosses frames.
// the output register takes the next request while a beat waits; two requests queue in front.
// reset clears the stack pointer, run state and queues; dimensions reset to 256 x 256.
// dimensions are latched at the start of each curve.
module generalized_hilbert_curve_walker #(
  parameter int unsigned MAX_DIM     = 4096,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ghcw_pkg::COORD_W-1:0]  point_x_o,
  output logic [ghcw_pkg::COORD_W-1:0]  point_y_o,
  output logic [ghcw_pkg::RASTER_W-1:0] raster_index_o,
  output logic                          last_point_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ghcw_pkg::*;

  localparam int unsigned DIMW = $clog2(MAX_DIM + 1);

  req_t            req;
  logic            take;
  logic [DIMW-1:0] dim_w, dim_h;

  // request intake and registers
  ghcw_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .restart_i  (restart_i),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .req_o      (req),
    .take_i     (take),
    .dim_w_o    (dim_w),
    .dim_h_o    (dim_h)
  );

  // curve walking
  ghcw_back #(
    .MAX_DIM     (MAX_DIM),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .take_o         (take),
    .dim_w_i        (dim_w),
    .dim_h_i        (dim_h),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .raster_index_o (raster_index_o),
    .last_point_o   (last_point_o)
  );

endmodule
